### src/color_matrix_convert_normalize_macros.svh
`ifndef COLOR_MATRIX_CONVERT_NORMALIZE_MACROS_SVH
`define COLOR_MATRIX_CONVERT_NORMALIZE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CCM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ccm_pkg.sv
`timescale 1ns / 1ps

package ccm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 18;
    localparam int NUM_LANES = 3;
    localparam int CFG_W     = NUM_LANES * COEF_W;
    // Q1.16 quotient: raw <= max, so the quotient never exceeds 1.0
    localparam int QUOT_W    = 17;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [OUT_W-1:0] OUT_MAX  = 18'h3FFFF;
    localparam logic [OUT_W-1:0] NORM_ONE = 18'h10000;

    typedef enum logic [1:0] {
        CFG_COEF_ROW0   = 2'd0,
        CFG_COEF_ROW1   = 2'd1,
        CFG_COEF_ROW2   = 2'd2,
        CFG_NORM_ENABLE = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        // coef[src][dst]
        logic [NUM_LANES-1:0][NUM_LANES-1:0][COEF_W-1:0] coef;
        logic                                            norm_en;
    } t_cfg;

    typedef struct packed {
        logic [NUM_LANES-1:0][OUT_W-1:0] raw;
        logic [OUT_W-1:0]                divisor;
        logic                            scale;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [NUM_LANES-1:0][OUT_W-1:0] ch;
        logic                            scaled;
    } t_result;

endpackage

### src/ccm_front.sv
`timescale 1ns / 1ps

module ccm_front import ccm_pkg::*; #(
    parameter int CHANNELS       = 3,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_cfg                                  i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [NUM_LANES-1:0][SAMPLE_W-1:0]    i_samples,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output t_job                                  o_job
);

    localparam int NCH    = (CHANNELS < NUM_LANES) ? CHANNELS : NUM_LANES;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;

    logic                                                   r_p1_vld;
    logic                                                   r_p2_vld;
    logic [NUM_LANES-1:0][NUM_LANES-1:0][PROD_W-1:0]        r_prod;
    logic [NUM_LANES-1:0][NUM_LANES-1:0][PROD_W-1:0]        n_prod;
    logic [NUM_LANES-1:0][OUT_W-1:0]                        r_raw;
    logic [NUM_LANES-1:0][OUT_W-1:0]                        n_raw;
    logic                                                   w_en;

    assign w_en    = !r_p2_vld || !i_q_full;
    assign o_ready = w_en;
    assign o_push  = r_p2_vld && w_en;

    // lanes outside the channel count contribute nothing
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                if (i < NCH && j < NCH) begin
                    n_prod[i][j] = PROD_W'(i_samples[i]) * PROD_W'(i_cfg.coef[i][j]);
                end else begin
                    n_prod[i][j] = '0;
                end
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] sh;
        for (int j = 0; j < NUM_LANES; j++) begin
            sum = SUM_W'(r_prod[0][j]) + SUM_W'(r_prod[1][j]) + SUM_W'(r_prod[2][j]);
            sh  = sum >> COEF_FRAC_BITS;
            n_raw[j] = (sh > SUM_W'(OUT_MAX)) ? OUT_MAX : sh[OUT_W-1:0];
        end
    end

    // max search, last index wins on ties
    always_comb begin
        logic [OUT_W-1:0] best;
        logic             idx_nz;
        best   = r_raw[0];
        idx_nz = 1'b0;
        for (int j = 1; j < NUM_LANES; j++) begin
            if (j < NCH && r_raw[j] >= best) begin
                best   = r_raw[j];
                idx_nz = 1'b1;
            end
        end
        o_job.raw     = r_raw;
        o_job.divisor = best;
        o_job.scale   = i_cfg.norm_en && idx_nz && (best != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= i_valid;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= n_prod;
            r_raw  <= n_raw;
        end
    end

endmodule

### src/ccm_queue.sv
`timescale 1ns / 1ps

module ccm_queue import ccm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_data,
    input  logic    i_pop,
    output t_job    o_data,
    output t_q_stat o_stat
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/ccm_back.sv
`timescale 1ns / 1ps

module ccm_back import ccm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    // one quotient bit per stage, MSB (the 1.0 bit) first
    localparam int NST = QUOT_W;

    logic [NST-1:0]                         r_vld;
    logic [NUM_LANES-1:0][OUT_W-1:0]        r_rem   [NST];
    logic [NUM_LANES-1:0][OUT_W-1:0]        n_rem   [NST];
    logic [NUM_LANES-1:0][QUOT_W-1:0]       r_q     [NST];
    logic [NUM_LANES-1:0][QUOT_W-1:0]       n_q     [NST];
    logic [NUM_LANES-1:0][OUT_W-1:0]        r_raw   [NST];
    logic [NUM_LANES-1:0][OUT_W-1:0]        n_raw   [NST];
    logic [OUT_W-1:0]                       r_div   [NST];
    logic [OUT_W-1:0]                       n_div   [NST];
    logic [NST-1:0]                         r_scale;
    logic [NST-1:0]                         n_scale;
    logic                                   r_out_vld;
    t_result                                r_out;
    t_result                                n_out;
    logic                                   w_en;

    assign w_en     = !r_out_vld || i_ready;
    assign o_pop    = w_en && !i_q_empty;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    always_comb begin
        logic [OUT_W:0]   trial;
        logic [OUT_W+1:0] diff;
        logic [QUOT_W-1:0] q_prev;
        logic             ge;
        for (int s = 0; s < NST; s++) begin
            if (s == 0) begin
                n_raw[s]   = i_job.raw;
                n_div[s]   = i_job.divisor;
                n_scale[s] = i_job.scale;
            end else begin
                n_raw[s]   = r_raw[s-1];
                n_div[s]   = r_div[s-1];
                n_scale[s] = r_scale[s-1];
            end
            for (int c = 0; c < NUM_LANES; c++) begin
                if (s == 0) begin
                    // raw never exceeds the max, so the first bit needs no shift
                    trial  = {1'b0, i_job.raw[c]};
                    q_prev = '0;
                end else begin
                    trial  = {r_rem[s-1][c], 1'b0};
                    q_prev = r_q[s-1][c];
                end
                diff = {1'b0, trial} - {2'b00, n_div[s]};
                ge   = !diff[OUT_W+1];
                n_rem[s][c] = ge ? diff[OUT_W-1:0] : trial[OUT_W-1:0];
                n_q[s][c]   = {q_prev[QUOT_W-2:0], ge};
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            n_out.ch[c] = r_scale[NST-1] ? OUT_W'(r_q[NST-1][c]) : r_raw[NST-1][c];
        end
        n_out.scaled = r_scale[NST-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NST-2:0], !i_q_empty};
            r_out_vld <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_raw[s] <= n_raw[s];
                r_div[s] <= n_div[s];
            end
            r_scale <= n_scale;
            r_out   <= n_out;
        end
    end

endmodule

### src/color_matrix_convert_normalize.sv
// 3x3 color correction with optional max-normalization. Each transfer on the
// slave stream carries one pixel of three unsigned 16-bit samples. The block
// multiplies it by the unsigned coefficient matrix in the coef_row registers
// and saturates each target to 18 bits. When normalization is on and the
// largest target (last index on ties) is neither target 0 nor zero, every
// target is divided by that maximum into Q1.16. One pixel is taken per clock
// and one result is delivered per clock while neither stream stalls. From the
// input transfer to the output transfer a pixel passes the multiply register,
// the sum and saturate register, the four-entry queue, 17 stages of the
// restoring divider (one quotient bit each), and the output register. The queue
// lets the matrix front end keep accepting pixels while the master side stalls.
// Coefficient and enable writes must happen while no pixel is in flight.
`timescale 1ns / 1ps

`include "color_matrix_convert_normalize_macros.svh"

module color_matrix_convert_normalize import ccm_pkg::*; #(
    parameter int CHANNELS       = 3,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // in_ch0 [15:0], in_ch1 [31:16], in_ch2 [47:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // out_ch0 [17:0], out_ch1 [35:18], out_ch2 [53:36]
    output logic         m_axis_tuser   // was_scaled
);

    t_cfg    r_cfg;
    t_job    w_front_job;
    t_job    w_head_job;
    t_q_stat w_q_stat;
    t_result w_result;
    logic    w_push;
    logic    w_pop;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] w_samples;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef    <= '0;
            r_cfg.norm_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_COEF_ROW0:   r_cfg.coef[0] <= i_cfg_wdata[CFG_W-1:0];
                CFG_COEF_ROW1:   r_cfg.coef[1] <= i_cfg_wdata[CFG_W-1:0];
                CFG_COEF_ROW2:   r_cfg.coef[2] <= i_cfg_wdata[CFG_W-1:0];
                CFG_NORM_ENABLE: r_cfg.norm_en <= i_cfg_wdata[0];
                default:         r_cfg.norm_en <= r_cfg.norm_en;
            endcase
        end
    end

    assign w_samples = s_axis_tdata;

    ccm_front #(
        .CHANNELS       (CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_samples (w_samples),
        .i_q_full  (w_q_stat.full),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    ccm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_stat  (w_q_stat)
    );

    ccm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_stat.empty),
        .i_job     (w_head_job),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (w_result)
    );

    assign m_axis_tdata = {2'b00, w_result.ch};
    assign m_axis_tuser = w_result.scaled;

    // the maximum channel always divides to exactly 1.0
    `CCM_ASSERT_IMPLY(a_scaled_has_unity, m_axis_tvalid && w_result.scaled, (w_result.ch[0] == NORM_ONE) || (w_result.ch[1] == NORM_ONE) || (w_result.ch[2] == NORM_ONE), "scaled pixel without a unity channel")
    `CCM_ASSERT_IMPLY(a_scaled_bounded, m_axis_tvalid && w_result.scaled, (w_result.ch[0] <= NORM_ONE) && (w_result.ch[1] <= NORM_ONE) && (w_result.ch[2] <= NORM_ONE), "normalized channel above 1.0")
    `CCM_ASSERT_IMPLY(a_scaled_needs_enable, m_axis_tvalid && w_result.scaled, r_cfg.norm_en, "scaled result with normalization off")
    `CCM_ASSERT_IMPLY(a_stall_only_when_full, !s_axis_tready, w_q_stat.full, "front stalled with room in the queue")
    `CCM_ASSERT_NEXT(a_queue_fills, w_push && !w_pop, !w_q_stat.empty, "queue empty after a push")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench import ccm_pkg::*;;

    localparam int FRAC_BITS     = 15;
    localparam int PHASES        = 8;
    localparam int PHASE_PIXELS  = 50;
    localparam int PRESSURE_HOLD = 300;
    localparam int DRAIN_CYCLES  = 40;

    class ccm_scoreboard;
        logic [COEF_W-1:0] coef [NUM_LANES][NUM_LANES];
        logic              norm_en;
        t_result           pending[$];
        int                mismatches;
        int                results_seen;
        int                scaled_seen;
        int                saturated_seen;
        bit                last_saturated;

        function new();
            foreach (coef[i, j]) coef[i][j] = '0;
            norm_en = 1'b1;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_COEF_ROW0, CFG_COEF_ROW1, CFG_COEF_ROW2: begin
                    for (int j = 0; j < NUM_LANES; j++)
                        coef[int'(idx)][j] = val[COEF_W*j +: COEF_W];
                end
                CFG_NORM_ENABLE: begin
                    norm_en = val[0];
                end
                default: ;
            endcase
        endfunction

        // matrix product, saturate, then, when scaling applies, divide by the peak target into Q1.16
        function t_result predict_pixel(logic [3*SAMPLE_W-1:0] px);
            logic [39:0]      acc;
            logic [39:0]      quot;
            logic [OUT_W-1:0] raw [NUM_LANES];
            logic [OUT_W-1:0] peak;
            int               peak_lane;
            t_result          r;
            last_saturated = 1'b0;
            for (int j = 0; j < NUM_LANES; j++) begin
                acc = '0;
                for (int i = 0; i < NUM_LANES; i++)
                    acc += px[SAMPLE_W*i +: SAMPLE_W] * coef[i][j];
                acc = acc >> FRAC_BITS;
                if (acc > OUT_MAX) begin
                    raw[j] = OUT_MAX;
                    last_saturated = 1'b1;
                end else begin
                    raw[j] = acc[OUT_W-1:0];
                end
            end
            // ties go to the higher lane
            peak = raw[0];
            peak_lane = 0;
            for (int j = 1; j < NUM_LANES; j++) begin
                if (raw[j] >= peak) begin
                    peak = raw[j];
                    peak_lane = j;
                end
            end
            r.scaled = norm_en && peak_lane != 0 && peak != 0;
            for (int j = 0; j < NUM_LANES; j++) begin
                if (r.scaled) begin
                    quot = ({22'd0, raw[j]} * NORM_ONE) / peak;
                    r.ch[j] = quot[OUT_W-1:0];
                end else begin
                    r.ch[j] = raw[j];
                end
            end
            return r;
        endfunction

        function void note_pixel(logic [3*SAMPLE_W-1:0] px);
            pending.insert(pending.size(), predict_pixel(px));
            if (last_saturated)
                saturated_seen++;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [55:0] data, logic scaled);
            t_result want;
            logic [OUT_W-1:0] got;
            results_seen++;
            if (pending.size() == 0) begin
                report($sformatf("result %h/%b with nothing outstanding", data, scaled));
                return;
            end
            want = pending.pop_front();
            if (want.scaled)
                scaled_seen++;
            for (int j = 0; j < NUM_LANES; j++) begin
                got = data[OUT_W*j +: OUT_W];
                if (got !== want.ch[j])
                    report($sformatf("result %0d out_ch%0d got %0d want %0d",
                                     results_seen, j, got, want.ch[j]));
            end
            if (scaled !== want.scaled)
                report($sformatf("result %0d was_scaled got %b want %b",
                                 results_seen, scaled, want.scaled));
            if (data[55:54] !== 2'b00)
                report($sformatf("result %0d tdata padding %b", results_seen, data[55:54]));
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [1:0]              i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [3*SAMPLE_W-1:0]   s_axis_tdata;   // in_ch0 [15:0], in_ch1 [31:16], in_ch2 [47:32]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [55:0]             m_axis_tdata;   // out_ch0 [17:0], out_ch1 [35:18], out_ch2 [53:36]
    logic                    m_axis_tuser;   // was_scaled

    ccm_scoreboard sb;
    bit  sender_idle_en = 1'b1;
    bit  recv_idle_en   = 1'b1;
    int  recv_hold      = 0;
    int  pixels_sent    = 0;
    int  settings_used  = 0;
    int  input_stalls   = 0;

    color_matrix_convert_normalize dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // transfer monitor: predict on input, compare on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata);
            if (s_axis_tvalid && !s_axis_tready)
                input_stalls++;
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // output side backpressure
    initial begin
        forever begin
            if (recv_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (recv_hold) @(posedge i_clk);
                recv_hold = 0;
            end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [3*SAMPLE_W-1:0] pack_pixel(logic [15:0] c0, logic [15:0] c1,
                                                         logic [15:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // 0 full range, 1 Q1.15 range, 2 equal across targets, 3 one unit coef, 4 zero or max
    function automatic logic [CFG_W-1:0] rand_row(int mode);
        logic [CFG_W-1:0]  row;
        logic [COEF_W-1:0] shared;
        int                pick;
        shared = 16'($urandom);
        pick = $urandom_range(0, NUM_LANES - 1);
        for (int j = 0; j < NUM_LANES; j++) begin
            case (mode)
                0:       row[COEF_W*j +: COEF_W] = 16'($urandom);
                1:       row[COEF_W*j +: COEF_W] = 16'($urandom_range(0, 32768));
                2:       row[COEF_W*j +: COEF_W] = shared;
                3:       row[COEF_W*j +: COEF_W] = (j == pick) ? 16'h8000 : 16'h0000;
                default: row[COEF_W*j +: COEF_W] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
        end
        return row;
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_config(logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1,
                               logic [CFG_W-1:0] r2, logic norm);
        write_reg(CFG_COEF_ROW0, r0);
        write_reg(CFG_COEF_ROW1, r1);
        write_reg(CFG_COEF_ROW2, r2);
        write_reg(CFG_NORM_ENABLE, {47'd0, norm});
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pixel(logic [3*SAMPLE_W-1:0] px);
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    initial begin
        int mode;
        logic norm;
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_COEF_ROW0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset matrix is all zero: peak of zero, unscaled zero targets back
        send_pixel(pack_pixel(16'h0000, 16'h0000, 16'h0000));
        send_pixel(pack_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
        drain_results();

        // identity: peak in lane 0, ties, zero peak
        load_config(48'h0000_0000_8000, 48'h0000_8000_0000, 48'h8000_0000_0000, 1'b1);
        send_pixel(pack_pixel(16'hFFFF, 16'h0000, 16'h0000));
        send_pixel(pack_pixel(16'h0000, 16'hFFFF, 16'h0000));
        send_pixel(pack_pixel(16'h0001, 16'h0002, 16'h0003));
        send_pixel(pack_pixel(16'h0005, 16'h0005, 16'h0005));
        send_pixel(pack_pixel(16'hFFFF, 16'hFFFF, 16'h0000));
        send_pixel(pack_pixel(16'h0000, 16'h0000, 16'h0000));
        drain_results();

        // all coefficients at max: a full-scale pixel saturates every target
        load_config(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_pixel(pack_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pack_pixel(16'h8000, 16'h0000, 16'h0001));
        drain_results();

        // normalization off
        load_config(rand_row(0), rand_row(0), rand_row(0), 1'b0);
        send_pixel(pack_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_pixel(pack_pixel(16'h0000, 16'h0000, 16'h0000));
        send_pixel(pack_pixel(16'h1234, 16'hABCD, 16'h5A5A));
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            mode = ph % 5;
            if (ph == 0)
                norm = 1'b1;
            else if (ph == 6)
                norm = 1'b0;
            else
                norm = ($urandom_range(0, 3) != 0);
            if (ph == PHASES - 1) begin
                sender_idle_en = 1'b0;
                recv_idle_en   = 1'b0;
            end
            load_config(rand_row(mode), rand_row(mode), rand_row(mode), norm);
            if (ph == 2) begin
                // long output stall with the input kept busy
                sender_idle_en = 1'b0;
                recv_hold      = PRESSURE_HOLD;
            end
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                if (ph == 4 && n == PHASE_PIXELS / 2)
                    drain_results();
                send_pixel(pack_pixel(rand_sample(), rand_sample(), rand_sample()));
            end
            drain_results();
            if (ph == 2)
                sender_idle_en = 1'b1;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixels over %0d matrix settings; %0d normalized, %0d saturated.",
                 pixels_sent, settings_used, sb.scaled_seen, sb.saturated_seen);
        $display("%0d results checked, input held off %0d cycles, %0d mismatches.",
                 sb.results_seen, input_stalls, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
